// ===== rtl/akvt_pkg.sv =====
// Package for the account key/value table: item types, datapath command and
// status structs, and result kind codes. Depends on nothing.
`timescale 1ns / 1ps

package akvt_pkg;

    typedef struct packed {
        logic        func;
        logic [63:0] key_word_0;
        logic [63:0] key_word_1;
        logic [63:0] key_word_2;
        logic [63:0] key_word_3;
        logic [63:0] new_balance;
        logic [63:0] new_nonce;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [63:0] balance_out;
        logic [63:0] nonce_out;
        logic        table_full;
        logic [5:0]  entry_index;
    } t_out_item;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_SET    = 1'b1;

    // Result kinds that the controller hands to the datapath.
    localparam logic [2:0] KIND_LOOKUP_MISS = 3'd0;
    localparam logic [2:0] KIND_LOOKUP_HIT  = 3'd1;
    localparam logic [2:0] KIND_SET_HIT     = 3'd2;
    localparam logic [2:0] KIND_INSERT      = 3'd3;
    localparam logic [2:0] KIND_FULL        = 3'd4;

    typedef struct packed {
        logic       start;     // capture the request, restart the scan
        logic       issue;     // read the next occupied key slot
        logic       dat_rd;    // read balance and nonce at the matched slot
        logic       dat_wr;    // write balance and nonce
        logic       key_wr;    // append the key at the next free slot
        logic       finish;    // form the result of the given kind
        logic [2:0] kind;
        logic       publish;   // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic is_set;     // the captured request is a set
        logic more;       // occupied slots remain to be read
        logic cmp_valid;  // a key read last cycle is being compared
        logic hit;        // that key matches the request
        logic full;       // every slot is occupied
        logic out_free;   // the output register can take a result
    } t_sts;

endpackage

// ===== rtl/akvt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module akvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/akvt_ctrl.sv =====
// Controller of the account key/value table: sequences capture, key scan,
// store updates and result hand-off. Depends on akvt_pkg.
`timescale 1ns / 1ps

module akvt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  akvt_pkg::t_sts i_sts,
    output akvt_pkg::t_cmd o_cmd
);

    import akvt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_LREAD = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.start = 1'b1;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                priority if (i_sts.hit) begin
                    if (i_sts.is_set == FUNC_SET) begin
                        cmd.dat_wr = 1'b1;
                        cmd.finish = 1'b1;
                        cmd.kind   = KIND_SET_HIT;
                        n_state    = S_RESP;
                    end else begin
                        cmd.dat_rd = 1'b1;
                        n_state    = S_LREAD;
                    end
                end else if (i_sts.more) begin
                    cmd.issue = 1'b1;
                end else if (!i_sts.cmp_valid) begin
                    cmd.finish = 1'b1;
                    n_state    = S_RESP;
                    priority if (i_sts.is_set != FUNC_SET) begin
                        cmd.kind = KIND_LOOKUP_MISS;
                    end else if (i_sts.full) begin
                        cmd.kind = KIND_FULL;
                    end else begin
                        cmd.kind   = KIND_INSERT;
                        cmd.key_wr = 1'b1;
                        cmd.dat_wr = 1'b1;
                    end
                end else begin
                    // Last key still in comparison: wait for it.
                    n_state = S_SCAN;
                end
            end
            S_LREAD: begin
                cmd.finish = 1'b1;
                cmd.kind   = KIND_LOOKUP_HIT;
                n_state    = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    cmd.publish = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

// ===== rtl/akvt_dp.sv =====
// Datapath of the account key/value table: request register, key and value
// memories, scan counters, comparator and result registers.
// Depends on akvt_pkg and akvt_ram.
`timescale 1ns / 1ps

module akvt_dp #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  akvt_pkg::t_in_item  i_in_item,
    input  akvt_pkg::t_cmd      i_cmd,
    output akvt_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output akvt_pkg::t_out_item o_out_item
);

    import akvt_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    t_in_item    r_req;
    logic [CW-1:0] r_used;
    logic [CW-1:0] r_issue;
    logic          r_cmp_valid;
    logic [IW-1:0] r_cmp_slot;
    t_out_item     r_res;
    t_out_item     n_res;
    t_out_item     r_out;
    logic          r_out_valid;

    logic [255:0]  key_q;
    logic [127:0]  dat_q;
    logic [255:0]  req_key;
    logic          match;
    logic [IW-1:0] used_slot;
    logic [IW-1:0] dat_waddr;
    logic [5:0]    cmp_idx;
    logic [5:0]    ins_idx;
    logic [IW+5:0] cmp_ext;
    logic [IW+5:0] ins_ext;

    assign req_key   = {r_req.key_word_3, r_req.key_word_2, r_req.key_word_1, r_req.key_word_0};
    assign used_slot = r_used[IW-1:0];
    assign dat_waddr = i_cmd.key_wr ? used_slot : r_cmp_slot;
    assign match     = r_cmp_valid && (key_q == req_key);

    // The reported slot is the low six bits of the slot number.
    assign cmp_ext = {6'd0, r_cmp_slot};
    assign ins_ext = {6'd0, used_slot};
    assign cmp_idx = cmp_ext[5:0];
    assign ins_idx = ins_ext[5:0];

    akvt_ram #(
        .WIDTH (256),
        .DEPTH (TABLE_ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.key_wr),
        .i_waddr (used_slot),
        .i_wdata (req_key),
        .i_re    (i_cmd.issue),
        .i_raddr (r_issue[IW-1:0]),
        .o_rdata (key_q)
    );

    akvt_ram #(
        .WIDTH (128),
        .DEPTH (TABLE_ENTRIES)
    ) u_dat_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.dat_wr),
        .i_waddr (dat_waddr),
        .i_wdata ({r_req.new_balance, r_req.new_nonce}),
        .i_re    (i_cmd.dat_rd),
        .i_raddr (r_cmp_slot),
        .o_rdata (dat_q)
    );

    // Result of the kind that the controller names.
    always_comb begin
        n_res = '0;
        unique case (i_cmd.kind)
            KIND_LOOKUP_HIT: begin
                n_res.found       = 1'b1;
                n_res.balance_out = dat_q[127:64];
                n_res.nonce_out   = dat_q[63:0];
                n_res.entry_index = cmp_idx;
            end
            KIND_SET_HIT: begin
                n_res.found       = 1'b1;
                n_res.entry_index = cmp_idx;
            end
            KIND_INSERT: begin
                n_res.entry_index = ins_idx;
            end
            KIND_FULL: begin
                n_res.table_full = 1'b1;
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req <= i_in_item;
        end
        if (i_cmd.issue) begin
            r_cmp_slot <= r_issue[IW-1:0];
        end
        if (i_cmd.finish) begin
            r_res <= n_res;
        end
        if (i_cmd.publish) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_issue     <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.key_wr) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.start) begin
                r_issue <= '0;
            end else if (i_cmd.issue) begin
                r_issue <= r_issue + 1'b1;
            end
            r_cmp_valid <= i_cmd.issue;
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.is_set    = r_req.func;
    assign o_sts.more      = (r_issue < r_used);
    assign o_sts.cmp_valid = r_cmp_valid;
    assign o_sts.hit       = match;
    assign o_sts.full      = (r_used == CW'(TABLE_ENTRIES));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== rtl/account_key_value_table.sv =====
// Account key/value table: lookup or insert-or-update of 256-bit keys.
// The time from acceptance to result grows with N, the key slots read (the
// occupied count on a miss, the matched slot plus one on a hit); a set hit
// skips the value read, and a busy output stalls the result hand-off.
// One item is in work at a time; the scan reads one key per cycle.
// Reset (synchronous, active low) empties the table.
`timescale 1ns / 1ps

// The table keeps its keys in one memory and balance/nonce pairs in another,
// both filled in insertion order. An occupancy count marks how many slots hold
// data, so nothing is read before it has been written and no clearing pass is
// needed after reset.
//
// A request is captured in the idle state, then the controller reads the key
// memory one slot per cycle while the datapath compares the key read in the
// previous cycle with the request. The first matching slot ends the scan. A
// lookup hit then reads the value memory; a set hit overwrites the value; a
// set miss appends key and value at the next free slot, or flags a full table.
//
// The result sits in an output register, so the next item is accepted while
// the previous result still waits to be taken.

module account_key_value_table #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  akvt_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output akvt_pkg::t_out_item o_out_item
);

    import akvt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencing of each item.
    akvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Storage, comparison and the output register.
    akvt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/akvt_checker.sv =====
// Port-level checks for the account key/value table, bound to the top level.
// Depends on akvt_pkg and account_key_value_table.
`timescale 1ns / 1ps

module akvt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input akvt_pkg::t_out_item o_out_item
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before it was taken");

    // Reset leaves no result on offer.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while one is in work");

    // A full-table result carries nothing else.
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.table_full |->
            !o_out_item.found && (o_out_item.entry_index == 6'd0) &&
            (o_out_item.balance_out == 64'd0) && (o_out_item.nonce_out == 64'd0))
        else $error("full-table result with other fields set");

    // A miss reports zero balance and nonce.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.found |->
            (o_out_item.balance_out == 64'd0) && (o_out_item.nonce_out == 64'd0))
        else $error("miss with non-zero balance or nonce");

endmodule

bind account_key_value_table akvt_checker u_akvt_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the account key/value table: lookups, updates,
// inserts and drops on a full table, checked against an in-bench predictor.
// Depends on akvt_pkg and account_key_value_table.
`timescale 1ns / 1ps

module tb;

    import akvt_pkg::*;

    localparam int TABLE_ENTRIES = 64;
    localparam int N_RANDOM      = 550;
    localparam int POOL_KEYS     = 100;
    // The longest item fits well inside this settling wait.
    localparam int SETTLE_CYCLES = 100;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;

    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // Percentage of cycles in which each side idles, per phase of the run.
    // The sender is eager and the receiver busy first, then the reverse,
    // and finally neither side holds back at all.
    int        send_idle_pct [3] = '{24, 74, 0};
    int        recv_idle_pct [3] = '{74, 24, 0};
    int        cur_phase = 0;

    // Requests waiting to be driven, with the phase each belongs to and
    // whether the driver must first wait for every reply to come back.
    t_in_item  request_q[$];
    bit        drain_first_q[$];
    int        request_phase_q[$];

    t_out_item expected_reply_q[$];

    // Shadow of the table contents, kept in insertion order.
    logic [255:0] acct_key     [TABLE_ENTRIES];
    logic [63:0]  acct_balance [TABLE_ENTRIES];
    logic [63:0]  acct_nonce   [TABLE_ENTRIES];
    int           acct_count = 0;

    int        replies_owed   = 0;
    int        mismatch_count = 0;
    int        n_replies      = 0;
    int        n_lookup_hit   = 0;
    int        n_lookup_miss  = 0;
    int        n_update       = 0;
    int        n_insert       = 0;
    int        n_dropped      = 0;

    logic [255:0] key_pool [POOL_KEYS];

    account_key_value_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Works out the reply to one request and applies its effect to the
    // shadow table. The first matching slot wins, as in the block.
    function automatic t_out_item predict_account_reply(input t_in_item req);
        t_out_item    rep;
        logic [255:0] key;
        int           slot;
        rep  = '0;
        key  = {req.key_word_3, req.key_word_2, req.key_word_1, req.key_word_0};
        slot = -1;
        for (int i = 0; i < acct_count; i++) begin
            if (slot < 0 && acct_key[i] == key) begin
                slot = i;
            end
        end
        if (req.func == FUNC_LOOKUP) begin
            if (slot >= 0) begin
                rep.found       = 1'b1;
                rep.balance_out = acct_balance[slot];
                rep.nonce_out   = acct_nonce[slot];
                rep.entry_index = slot[5:0];
                n_lookup_hit++;
            end else begin
                n_lookup_miss++;
            end
        end else if (slot >= 0) begin
            // An update reports the slot but returns no values.
            acct_balance[slot] = req.new_balance;
            acct_nonce[slot]   = req.new_nonce;
            rep.found          = 1'b1;
            rep.entry_index    = slot[5:0];
            n_update++;
        end else if (acct_count < TABLE_ENTRIES) begin
            acct_key[acct_count]     = key;
            acct_balance[acct_count] = req.new_balance;
            acct_nonce[acct_count]   = req.new_nonce;
            rep.entry_index          = acct_count[5:0];
            acct_count++;
            n_insert++;
        end else begin
            // No free slot: the request is dropped and only the flag is set.
            rep.table_full = 1'b1;
            n_dropped++;
        end
        return rep;
    endfunction

    task automatic queue_request(input logic f, input logic [255:0] key,
                                 input logic [63:0] bal, input logic [63:0] non,
                                 input bit drain, input int ph);
        t_in_item req;
        req.func        = f;
        req.key_word_0  = key[63:0];
        req.key_word_1  = key[127:64];
        req.key_word_2  = key[191:128];
        req.key_word_3  = key[255:192];
        req.new_balance = bal;
        req.new_nonce   = non;
        request_q       = {request_q, req};
        drain_first_q   = {drain_first_q, drain};
        request_phase_q = {request_phase_q, ph};
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Request driver. It keeps its own count of replies still owed, built
    // from the handshakes seen at each edge, so that a drain point does not
    // depend on the order in which the two clocked blocks run.
    always @(posedge i_clk) begin : request_driver
        t_in_item  nxt;
        t_out_item exp_rep;
        bit        took;
        bit        gave;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            took = in_valid && in_ready;
            gave = out_valid && out_ready;
            if (took) begin
                exp_rep          = predict_account_reply(in_item);
                expected_reply_q = {expected_reply_q, exp_rep};
            end
            replies_owed = replies_owed + int'(took) - int'(gave);
            if (!in_valid || took) begin
                if (request_q.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (drain_first_q[0] && replies_owed != 0) begin
                    in_valid <= 1'b0;
                end else if ($urandom_range(99) < send_idle_pct[request_phase_q[0]]) begin
                    in_valid <= 1'b0;
                end else begin
                    nxt = request_q.pop_front();
                    void'(drain_first_q.pop_front());
                    cur_phase <= request_phase_q.pop_front();
                    in_valid  <= 1'b1;
                    in_item   <= nxt;
                end
            end
        end
    end

    // Reply monitor: every reply is compared field by field with the oldest
    // expectation, and the ready line is drawn at random with the idle share of the phase.
    always @(posedge i_clk) begin : reply_monitor
        t_out_item want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                n_replies++;
                if (expected_reply_q.size() == 0) begin
                    report_mismatch("reply arrived with no request outstanding");
                end else begin
                    want = expected_reply_q.pop_front();
                    if (out_item.found !== want.found)
                        report_mismatch($sformatf("reply %0d found %b, want %b",
                            n_replies, out_item.found, want.found));
                    if (out_item.balance_out !== want.balance_out)
                        report_mismatch($sformatf("reply %0d balance %h, want %h",
                            n_replies, out_item.balance_out, want.balance_out));
                    if (out_item.nonce_out !== want.nonce_out)
                        report_mismatch($sformatf("reply %0d nonce %h, want %h",
                            n_replies, out_item.nonce_out, want.nonce_out));
                    if (out_item.table_full !== want.table_full)
                        report_mismatch($sformatf("reply %0d table_full %b, want %b",
                            n_replies, out_item.table_full, want.table_full));
                    if (out_item.entry_index !== want.entry_index)
                        report_mismatch($sformatf("reply %0d entry_index %0d, want %0d",
                            n_replies, out_item.entry_index, want.entry_index));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct[cur_phase]);
        end
    end

    // Stimulus, reset and end of run.
    initial begin : run_control
        logic [255:0] key;
        logic [63:0]  bal;
        logic [63:0]  non;
        int           ph;
        int           prev_ph;
        int           pick;

        // Directed part. Lookup on an empty table, then the all-zero and
        // all-ones keys inserted, read back, updated and read again.
        queue_request(FUNC_LOOKUP, '0, '1, '1, 1'b0, 0);
        queue_request(FUNC_SET,    '0, '1, '0, 1'b0, 0);
        queue_request(FUNC_LOOKUP, '0, '0, '0, 1'b0, 0);
        queue_request(FUNC_SET,    '1, '0, '1, 1'b0, 0);
        queue_request(FUNC_LOOKUP, '1, rand64(), rand64(), 1'b0, 0);
        // Near misses: keys that differ from a stored one in a single word.
        for (int w = 0; w < 4; w++) begin
            key = '1;
            key[w*64 +: 64] = '0;
            queue_request(FUNC_LOOKUP, key, '0, '0, 1'b0, 0);
        end
        for (int w = 0; w < 4; w++) begin
            key = '0;
            key[w*64 + 63] = 1'b1;
            queue_request(FUNC_LOOKUP, key, '0, '0, 1'b0, 0);
        end
        queue_request(FUNC_SET,    '0, rand64(), rand64(), 1'b0, 0);
        queue_request(FUNC_LOOKUP, '0, '0, '0, 1'b0, 0);
        queue_request(FUNC_SET,    '1, '1, '1, 1'b0, 0);
        queue_request(FUNC_LOOKUP, '1, '0, '0, 1'b0, 0);
        key = {rand64(), rand64(), rand64(), rand64()};
        queue_request(FUNC_SET,    key, rand64(), rand64(), 1'b0, 0);
        queue_request(FUNC_LOOKUP, key, rand64(), rand64(), 1'b0, 0);

        // Random part. Most keys come from a pool small enough to revisit
        // entries often yet large enough to fill the table; the rest are
        // near misses of pool keys or fresh keys.
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_KEYS; i++) begin
            key_pool[i] = {rand64(), rand64(), rand64(), rand64()};
        end
        prev_ph = -1;
        for (int i = 0; i < N_RANDOM; i++) begin
            ph   = i * 3 / N_RANDOM;
            pick = $urandom_range(99);
            if (pick < 60) begin
                key = key_pool[$urandom_range(POOL_KEYS - 1)];
            end else if (pick < 70) begin
                key = key_pool[$urandom_range(POOL_KEYS - 1)];
                key[$urandom_range(3)*64 +: 64] = rand64();
            end else if (pick < 80) begin
                key = key_pool[$urandom_range(POOL_KEYS - 1)];
                key[$urandom_range(255)] ^= 1'b1;
            end else begin
                key = {rand64(), rand64(), rand64(), rand64()};
            end
            pick = $urandom_range(9);
            bal  = (pick == 0) ? '0 : (pick == 1) ? '1 : rand64();
            pick = $urandom_range(9);
            non  = (pick == 0) ? '0 : (pick == 1) ? '1 : rand64();
            // Each phase opens only once the previous one has fully drained.
            queue_request($urandom_range(1) ? FUNC_SET : FUNC_LOOKUP, key, bal, non,
                          ph != prev_ph, ph);
            prev_ph = ph;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (request_q.size() != 0 || in_valid || expected_reply_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d replies: %0d lookup hits, %0d lookup misses, %0d updates",
                 n_replies, n_lookup_hit, n_lookup_miss, n_update);
        $display("  %0d inserts (table holds %0d of %0d), %0d sets dropped on a full table",
                 n_insert, acct_count, TABLE_ENTRIES, n_dropped);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog, set well beyond the slowest correct run.
    initial begin : watchdog
        #1000000;
        $display("timeout with %0d replies still owed", expected_reply_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== account_key_value_table.f =====
rtl/akvt_pkg.sv
rtl/akvt_ram.sv
rtl/akvt_ctrl.sv
rtl/akvt_dp.sv
rtl/account_key_value_table.sv
rtl/akvt_checker.sv
tb/sv/tb.sv
